// ===== rtl/core/quaternion_to_rotation_matrix_defines.svh =====
`ifndef QUATERNION_TO_ROTATION_MATRIX_DEFINES_SVH
`define QUATERNION_TO_ROTATION_MATRIX_DEFINES_SVH

// Clocked on clk_i, off while rst_ni is low.
`define Q2R_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define Q2R_ASSERT_NEXT(lbl, ante, cons, msg) \
  `Q2R_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== rtl/core/q2r_pkg.sv =====
`default_nettype none

package q2r_pkg;

  localparam int unsigned QW   = 16;
  localparam int unsigned PW   = 32;
  localparam int unsigned AW   = 35;
  localparam int unsigned FRAC = 15;
  localparam int unsigned RW   = AW - FRAC;

  localparam int unsigned NProd = 9;
  localparam int unsigned NElem = 9;

  localparam int unsigned IXX = 0;
  localparam int unsigned IYY = 1;
  localparam int unsigned IZZ = 2;
  localparam int unsigned IXY = 3;
  localparam int unsigned IXZ = 4;
  localparam int unsigned IYZ = 5;
  localparam int unsigned IWX = 6;
  localparam int unsigned IWY = 7;
  localparam int unsigned IWZ = 8;

  typedef logic signed [QW-1:0] q15_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [AW-1:0] acc_t;
  typedef logic signed [RW-1:0] rnd_t;

  localparam acc_t Q30One    = 35'sd1073741824;
  localparam acc_t RoundHalf = 35'sd16384;
  localparam rnd_t Q15Max    = 20'sd32767;
  localparam rnd_t Q15Min    = -20'sd32768;

  // Q5.30 -> Q1.15, round half up, saturate.
  function automatic q15_t sat_q15(input acc_t m);
    acc_t t;
    rnd_t r;
    t = m + RoundHalf;
    r = $signed(t[AW-1:FRAC]);
    if (r > Q15Max) begin
      return q15_t'(Q15Max);
    end else if (r < Q15Min) begin
      return q15_t'(Q15Min);
    end
    return r[QW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/quaternion_to_rotation_matrix.sv =====
`default_nettype none

// Quaternion (w, x, y, z) in signed Q1.15 to the row-major 3x3 rotation matrix
// in signed Q1.15. The quaternion is used as given, not normalized; each element
// is formed exactly at Q5.30, rounded half up to Q1.15 and saturated to
// [-32768, 32767]. Three register stages: the nine products, the sums and
// differences, then rounding and saturation into the output register, which
// drives out_valid_o. One beat is accepted every cycle while the output is not
// stalled, and stall propagates stage by stage so empty stages keep filling
// while a result waits.
module quaternion_to_rotation_matrix (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire q2r_pkg::q15_t quat_w_i,
  input  wire q2r_pkg::q15_t quat_x_i,
  input  wire q2r_pkg::q15_t quat_y_i,
  input  wire q2r_pkg::q15_t quat_z_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output q2r_pkg::q15_t      r00_o,
  output q2r_pkg::q15_t      r01_o,
  output q2r_pkg::q15_t      r02_o,
  output q2r_pkg::q15_t      r10_o,
  output q2r_pkg::q15_t      r11_o,
  output q2r_pkg::q15_t      r12_o,
  output q2r_pkg::q15_t      r20_o,
  output q2r_pkg::q15_t      r21_o,
  output q2r_pkg::q15_t      r22_o
);

  logic           s1_valid, s1_ready, s2_ready, out_ready;
  logic           s2_valid_q, out_valid_q;
  q2r_pkg::prod_t prod [q2r_pkg::NProd];
  q2r_pkg::acc_t  p [q2r_pkg::NProd];
  q2r_pkg::acc_t  elem_d [q2r_pkg::NElem];
  q2r_pkg::acc_t  elem_q [q2r_pkg::NElem];
  q2r_pkg::q15_t  res_q [q2r_pkg::NElem];

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s2_ready   = !s2_valid_q || out_ready;
  assign s1_ready   = !s1_valid || s2_ready;
  assign in_stall_o = !s1_ready;

  q2r_mult_stage u_mult (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (s1_ready),
    .valid_i  (in_valid_i),
    .quat_w_i (quat_w_i),
    .quat_x_i (quat_x_i),
    .quat_y_i (quat_y_i),
    .quat_z_i (quat_z_i),
    .valid_o  (s1_valid),
    .prod_o   (prod)
  );

  always_comb begin
    for (int i = 0; i < q2r_pkg::NProd; i++) begin
      p[i] = q2r_pkg::acc_t'(prod[i]);
    end
    elem_d[0] = q2r_pkg::Q30One - ((p[q2r_pkg::IYY] + p[q2r_pkg::IZZ]) <<< 1);
    elem_d[1] = (p[q2r_pkg::IXY] - p[q2r_pkg::IWZ]) <<< 1;
    elem_d[2] = (p[q2r_pkg::IXZ] + p[q2r_pkg::IWY]) <<< 1;
    elem_d[3] = (p[q2r_pkg::IXY] + p[q2r_pkg::IWZ]) <<< 1;
    elem_d[4] = q2r_pkg::Q30One - ((p[q2r_pkg::IXX] + p[q2r_pkg::IZZ]) <<< 1);
    elem_d[5] = (p[q2r_pkg::IYZ] - p[q2r_pkg::IWX]) <<< 1;
    elem_d[6] = (p[q2r_pkg::IXZ] - p[q2r_pkg::IWY]) <<< 1;
    elem_d[7] = (p[q2r_pkg::IYZ] + p[q2r_pkg::IWX]) <<< 1;
    elem_d[8] = q2r_pkg::Q30One - ((p[q2r_pkg::IXX] + p[q2r_pkg::IYY]) <<< 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_valid_q <= s1_valid;
      end
      if (out_ready) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready) begin
      elem_q <= elem_d;
    end
    if (out_ready) begin
      for (int i = 0; i < q2r_pkg::NElem; i++) begin
        res_q[i] <= q2r_pkg::sat_q15(elem_q[i]);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign r00_o = res_q[0];
  assign r01_o = res_q[1];
  assign r02_o = res_q[2];
  assign r10_o = res_q[3];
  assign r11_o = res_q[4];
  assign r12_o = res_q[5];
  assign r20_o = res_q[6];
  assign r21_o = res_q[7];
  assign r22_o = res_q[8];

endmodule

`default_nettype wire

// ===== rtl/core/q2r_mult_stage.sv =====
`default_nettype none

module q2r_mult_stage (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                load_i,
  input  wire logic                valid_i,
  input  wire q2r_pkg::q15_t       quat_w_i,
  input  wire q2r_pkg::q15_t       quat_x_i,
  input  wire q2r_pkg::q15_t       quat_y_i,
  input  wire q2r_pkg::q15_t       quat_z_i,
  output logic                     valid_o,
  output q2r_pkg::prod_t           prod_o [q2r_pkg::NProd]
);

  q2r_pkg::prod_t w_ext, x_ext, y_ext, z_ext;
  q2r_pkg::prod_t prod_d [q2r_pkg::NProd];
  q2r_pkg::prod_t prod_q [q2r_pkg::NProd];
  logic           valid_q;

  assign w_ext = q2r_pkg::prod_t'(quat_w_i);
  assign x_ext = q2r_pkg::prod_t'(quat_x_i);
  assign y_ext = q2r_pkg::prod_t'(quat_y_i);
  assign z_ext = q2r_pkg::prod_t'(quat_z_i);

  always_comb begin
    prod_d[q2r_pkg::IXX] = x_ext * x_ext;
    prod_d[q2r_pkg::IYY] = y_ext * y_ext;
    prod_d[q2r_pkg::IZZ] = z_ext * z_ext;
    prod_d[q2r_pkg::IXY] = x_ext * y_ext;
    prod_d[q2r_pkg::IXZ] = x_ext * z_ext;
    prod_d[q2r_pkg::IYZ] = y_ext * z_ext;
    prod_d[q2r_pkg::IWX] = w_ext * x_ext;
    prod_d[q2r_pkg::IWY] = w_ext * y_ext;
    prod_d[q2r_pkg::IWZ] = w_ext * z_ext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;

endmodule

`default_nettype wire

// ===== rtl/core/q2r_checker.sv =====
`default_nettype none

`include "quaternion_to_rotation_matrix_defines.svh"

module q2r_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_stall_o,
  input wire q2r_pkg::q15_t quat_w_i,
  input wire q2r_pkg::q15_t quat_x_i,
  input wire q2r_pkg::q15_t quat_y_i,
  input wire q2r_pkg::q15_t quat_z_i,
  input wire logic          out_valid_o,
  input wire logic          out_stall_i,
  input wire q2r_pkg::q15_t r00_o,
  input wire q2r_pkg::q15_t r01_o,
  input wire q2r_pkg::q15_t r02_o,
  input wire q2r_pkg::q15_t r10_o,
  input wire q2r_pkg::q15_t r11_o,
  input wire q2r_pkg::q15_t r12_o,
  input wire q2r_pkg::q15_t r20_o,
  input wire q2r_pkg::q15_t r21_o,
  input wire q2r_pkg::q15_t r22_o
);

  logic         in_beat, out_held, pure_scalar, ident_out, id_beat;
  logic [143:0] out_bus;

  assign in_beat     = in_valid_i && !in_stall_o;
  assign out_held    = out_valid_o && out_stall_i;
  assign out_bus     = {r00_o, r01_o, r02_o, r10_o, r11_o, r12_o, r20_o, r21_o, r22_o};
  // any w with a zero vector part maps to the (saturated) identity
  assign pure_scalar = (quat_x_i == '0) && (quat_y_i == '0) && (quat_z_i == '0)
                       && (quat_w_i == quat_w_i);
  assign ident_out   = (r00_o == 16'sd32767) && (r11_o == 16'sd32767)
                       && (r22_o == 16'sd32767) && (r01_o == '0) && (r02_o == '0)
                       && (r10_o == '0) && (r12_o == '0) && (r20_o == '0)
                       && (r21_o == '0);
  assign id_beat     = in_beat && pure_scalar;

  `Q2R_ASSERT_NEXT(a_out_valid_hold, out_held, out_valid_o, "output beat dropped while stalled")
  `Q2R_ASSERT_NEXT(a_out_data_hold, out_held, $stable(out_bus), "stalled output beat changed")
  `Q2R_ASSERT(a_latency, in_beat ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o, "beat late")
  `Q2R_ASSERT(a_identity, id_beat ##1 !out_stall_i ##1 !out_stall_i |=> ident_out, "bad identity")

endmodule

bind quaternion_to_rotation_matrix q2r_checker u_q2r_checker (.*);

`default_nettype wire

// ===== bench/quaternion_to_rotation_matrix_test.sv =====
`timescale 1ns / 1ps

module quaternion_to_rotation_matrix_test;

  typedef logic [9*16-1:0] mat_t;

  localparam int NDir = 18;
  localparam int PhaseItems = 300;
  localparam int HoldCycles = 100;
  localparam int StallLimit = 4000;
  localparam longint UnitQ30 = 64'sd1073741824;
  localparam q2r_pkg::q15_t P = 16'sh7FFF;
  localparam q2r_pkg::q15_t N = 16'sh8000;
  localparam q2r_pkg::q15_t Z = 16'sh0000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  q2r_pkg::q15_t quat_w = '0;
  q2r_pkg::q15_t quat_x = '0;
  q2r_pkg::q15_t quat_y = '0;
  q2r_pkg::q15_t quat_z = '0;
  logic out_stall = 1'b0;
  logic [144:0] cur_exp = '0;

  logic in_stall_o;
  logic out_valid_o;
  q2r_pkg::q15_t r00_o, r01_o, r02_o, r10_o, r11_o, r12_o, r20_o, r21_o, r22_o;

  mat_t mat_q[$];
  int pending = 0;
  int n_errors = 0;
  int n_quats = 0;
  int n_mats = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left = 0;

  logic [63:0] dir_quat [NDir];
  logic [144:0] dir_mat [NDir];
  string elem_name [9] = '{"r00", "r01", "r02", "r10", "r11", "r12", "r20", "r21", "r22"};
  int idle_pcts [4] = '{0, 72, 0, 27};
  int stall_pcts [4] = '{0, 0, 72, 27};

  quaternion_to_rotation_matrix dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .quat_w_i    (quat_w),
    .quat_x_i    (quat_x),
    .quat_y_i    (quat_y),
    .quat_z_i    (quat_z),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .r00_o       (r00_o),
    .r01_o       (r01_o),
    .r02_o       (r02_o),
    .r10_o       (r10_o),
    .r11_o       (r11_o),
    .r12_o       (r12_o),
    .r20_o       (r20_o),
    .r21_o       (r21_o),
    .r22_o       (r22_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Exact Q34.30 elements, round half up to Q1.15, saturate.
  function automatic mat_t rotation_of(input q2r_pkg::q15_t w, input q2r_pkg::q15_t x,
                                       input q2r_pkg::q15_t y, input q2r_pkg::q15_t z);
    longint sw, sx, sy, sz, r;
    longint e [9];
    mat_t m;
    sw = w;
    sx = x;
    sy = y;
    sz = z;
    e[0] = UnitQ30 - 2 * (sy * sy + sz * sz);
    e[1] = 2 * (sx * sy - sw * sz);
    e[2] = 2 * (sx * sz + sw * sy);
    e[3] = 2 * (sx * sy + sw * sz);
    e[4] = UnitQ30 - 2 * (sx * sx + sz * sz);
    e[5] = 2 * (sy * sz - sw * sx);
    e[6] = 2 * (sx * sz - sw * sy);
    e[7] = 2 * (sy * sz + sw * sx);
    e[8] = UnitQ30 - 2 * (sx * sx + sy * sy);
    for (int i = 0; i < 9; i++) begin
      r = (e[i] + 64'sd16384) >>> 15;
      if (r > 64'sd32767) begin
        r = 64'sd32767;
      end else if (r < -64'sd32768) begin
        r = -64'sd32768;
      end
      m[i*16 +: 16] = r[15:0];
    end
    return m;
  endfunction

  function automatic q2r_pkg::q15_t extreme_val();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh8001;
      2: return 16'shFFFF;
      3: return 16'sh0000;
      4: return 16'sh0001;
      5: return 16'sh7FFF;
      6: return 16'sh4000;
      default: return 16'shC000;
    endcase
  endfunction

  function automatic q2r_pkg::q15_t small_val();
    return q2r_pkg::q15_t'(int'($urandom_range(4095)) - 2048);
  endfunction

  function automatic logic [63:0] random_quat();
    real a, b, c, d, n, s;
    int sel;
    sel = $urandom_range(99);
    if (sel < 40) begin
      return {$urandom(), $urandom()};
    end else if (sel < 65) begin
      return {small_val(), small_val(), small_val(), small_val()};
    end else if (sel < 85) begin
      return {extreme_val(), extreme_val(), extreme_val(), extreme_val()};
    end
    // close to unit length
    a = real'(int'($urandom_range(65535)) - 32768);
    b = real'(int'($urandom_range(65535)) - 32768);
    c = real'(int'($urandom_range(65535)) - 32768);
    d = real'(int'($urandom_range(65535)) - 32768);
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n < 1.0) begin
      return {P, Z, Z, Z};
    end
    s = 32767.0 / n;
    return {q2r_pkg::q15_t'($rtoi(a * s)), q2r_pkg::q15_t'($rtoi(b * s)),
            q2r_pkg::q15_t'($rtoi(c * s)), q2r_pkg::q15_t'($rtoi(d * s))};
  endfunction

  task automatic send_quat(input logic [63:0] q, input logic [144:0] e);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    {quat_w, quat_x, quat_y, quat_z} <= q;
    cur_exp <= e;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin : monitor
    mat_t got, want;
    q2r_pkg::q15_t g, x;
    bit busy;
    busy = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        busy = 1'b1;
        got = {r22_o, r21_o, r20_o, r12_o, r11_o, r10_o, r02_o, r01_o, r00_o};
        if (pending == 0) begin
          $error("matrix beat with no quaternion pending");
          n_errors++;
        end else begin
          want = mat_q.pop_front();
          pending--;
          n_mats++;
          for (int i = 0; i < 9; i++) begin
            g = got[i*16 +: 16];
            x = want[i*16 +: 16];
            if (g !== x) begin
              $error("%s: expected %0d, got %0d", elem_name[i], x, g);
              n_errors++;
            end
          end
        end
      end
      if (in_valid && !in_stall_o) begin
        busy = 1'b1;
        n_quats++;
        if (cur_exp[144]) begin
          mat_q.push_back(cur_exp[143:0]);
        end else begin
          mat_q.push_back(rotation_of(quat_w, quat_x, quat_y, quat_z));
        end
        pending++;
      end
    end
    if (busy) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
  end

  initial begin : receiver
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_left = HoldCycles;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    while (idle_cycles < StallLimit) @(posedge clk_i);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    // row layout: {known, r22, r21, r20, r12, r11, r10, r02, r01, r00}
    dir_quat[0]  = {Z, Z, Z, Z};
    dir_mat[0]   = {1'b1, P, Z, Z, Z, P, Z, Z, Z, P};
    dir_quat[1]  = {P, Z, Z, Z};
    dir_mat[1]   = {1'b1, P, Z, Z, Z, P, Z, Z, Z, P};
    dir_quat[2]  = {N, Z, Z, Z};
    dir_mat[2]   = {1'b1, P, Z, Z, Z, P, Z, Z, Z, P};
    dir_quat[3]  = {Z, N, Z, Z};
    dir_mat[3]   = {1'b1, N, Z, Z, Z, N, Z, Z, Z, P};
    dir_quat[4]  = {Z, Z, N, Z};
    dir_mat[4]   = {1'b1, N, Z, Z, Z, P, Z, Z, Z, N};
    dir_quat[5]  = {Z, Z, Z, N};
    dir_mat[5]   = {1'b1, P, Z, Z, Z, N, Z, Z, Z, N};
    dir_quat[6]  = {16'h4000, 16'h4000, 16'h4000, 16'h4000};
    dir_mat[6]   = {1'b1, Z, P, Z, Z, Z, P, P, Z, Z};
    dir_quat[7]  = {Z, P, Z, Z};
    dir_quat[8]  = {P, P, P, P};
    dir_quat[9]  = {N, N, N, N};
    dir_quat[10] = {16'h4000, 16'hC000, 16'hC000, 16'hC000};
    dir_quat[11] = {16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA};
    dir_quat[12] = {16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555};
    // rounding ties, positive then negative
    dir_quat[13] = {Z, 16'h0080, 16'h0040, Z};
    dir_quat[14] = {Z, 16'hFF80, 16'h0040, Z};
    dir_quat[15] = {16'h5A82, 16'h5A82, Z, Z};
    dir_quat[16] = {16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF};
    dir_quat[17] = {N, P, N, P};
    for (int k = 7; k < NDir; k++) begin
      dir_mat[k] = '0;
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int k = 0; k < NDir; k++) begin
      send_quat(dir_quat[k], dir_mat[k]);
    end
    drain_results();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_pcts[p];
      recv_stall_pct = stall_pcts[p];
      for (int i = 0; i < PhaseItems; i++) begin
        if (p == 0 && i == 30) begin
          hold_req = 1'b1;
        end
        send_quat(random_quat(), '0);
      end
      drain_results();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain_results();
    repeat (8) @(posedge clk_i);

    $display("Covered %0d quaternions (%0d table rows, rest random), %0d matrices checked,",
             n_quats, NDir, n_mats);
    $display("under free flow, sparse input, heavy output stall, mixed gaps and a long hold.");
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
